>>> rtl/core/tpct_pkg.sv
// ----------------------------------------------------------------------------
// Pattern cell translator package
// Cell and result types, effect codes and command numbers.
// ----------------------------------------------------------------------------
package tpct_pkg;

  localparam logic [7:0] NOTE_LIMIT  = 8'd36;
  localparam logic [6:0] NOTE_OFFSET = 7'd48;
  localparam logic [7:0] VOL_MAX     = 8'h40;

  localparam logic [7:0] EFF_PORTA_DOWN = 8'd1;
  localparam logic [7:0] EFF_PORTA_UP   = 8'd2;
  localparam logic [7:0] EFF_ARP        = 8'd12;
  localparam logic [7:0] EFF_SLIDE_DN   = 8'd13;
  localparam logic [7:0] EFF_EXT        = 8'd15;
  localparam logic [7:0] EFF_FSLIDE_UP  = 8'd17;
  localparam logic [7:0] EFF_FSLIDE_DN  = 8'd21;
  localparam logic [7:0] EFF_JUMP       = 8'd25;
  localparam logic [7:0] EFF_RELEASE    = 8'd27;
  localparam logic [7:0] EFF_SPEED      = 8'd28;
  localparam logic [7:0] EFF_SLIDE_UP   = 8'd30;
  localparam logic [7:0] EFF_VOLUME     = 8'd31;

  localparam logic [3:0] CMD_IDLE       = 4'd0;
  localparam logic [3:0] CMD_PORTA_DOWN = 4'd1;
  localparam logic [3:0] CMD_PORTA_UP   = 4'd2;
  localparam logic [3:0] CMD_ARP        = 4'd3;
  localparam logic [3:0] CMD_SLIDE_DOWN = 4'd4;
  localparam logic [3:0] CMD_SLIDE_UP   = 4'd5;
  localparam logic [3:0] CMD_EXT        = 4'd6;
  localparam logic [3:0] CMD_JUMP       = 4'd7;
  localparam logic [3:0] CMD_TEMPO      = 4'd8;
  localparam logic [3:0] CMD_VOLSLIDE   = 4'd9;

  typedef struct packed {
    logic [7:0] note_code;
    logic [7:0] instrument_code;
    logic [7:0] effect_code;
    logic [7:0] effect_param;
  } tpct_cell_t;

  typedef struct packed {
    logic [6:0] note_out;
    logic       key_off;
    logic [7:0] instrument_out;
    logic       volume_set;
    logic [6:0] volume_value;
    logic [3:0] command_out;
    logic [7:0] param_out;
  } tpct_result_t;

endpackage

>>> rtl/core/tpct_xlate.sv
// ----------------------------------------------------------------------------
// Pattern cell translation logic
// Maps one raw cell to a normalized cell: note, instrument, volume, command.
// ----------------------------------------------------------------------------
module tpct_xlate
  import tpct_pkg::*;
(
  input  tpct_cell_t   raw,
  output tpct_result_t result
);

  logic [7:0] p;
  logic [3:0] lo;
  logic [3:0] sat15;
  logic [3:0] sat14;
  logic       note_ok;

  assign p       = raw.effect_param;
  assign lo      = p[3:0];
  assign sat15   = (p > 8'h0F) ? 4'hF : p[3:0];
  assign sat14   = (lo > 4'hE) ? 4'hE : lo;
  assign note_ok = (raw.note_code >= 8'd1) && (raw.note_code <= NOTE_LIMIT);

  always_comb begin
    result                = '0;
    result.param_out      = p;
    if (note_ok) begin
      result.note_out       = raw.note_code[6:0] + NOTE_OFFSET;
      result.instrument_out = raw.instrument_code + 8'd1;
    end
    case (raw.effect_code)
      EFF_PORTA_DOWN: begin
        result.command_out = CMD_PORTA_DOWN;
        result.param_out   = {4'h0, lo};
      end
      EFF_PORTA_UP: begin
        result.command_out = CMD_PORTA_UP;
        result.param_out   = {4'h0, lo};
      end
      EFF_ARP: begin
        if (p != 8'h00) result.command_out = CMD_ARP;
        else            result.param_out   = 8'h00;
      end
      EFF_SLIDE_DN, EFF_SLIDE_UP: begin
        if (p != 8'h00) begin
          result.command_out = (raw.effect_code == EFF_SLIDE_DN) ? CMD_SLIDE_DOWN
                                                                : CMD_SLIDE_UP;
          result.param_out   = {4'h1, sat15};
        end else begin
          result.param_out = 8'h00;
        end
      end
      EFF_FSLIDE_DN, EFF_FSLIDE_UP: begin
        if (p != 8'h00) begin
          result.command_out = (raw.effect_code == EFF_FSLIDE_DN) ? CMD_SLIDE_DOWN
                                                                 : CMD_SLIDE_UP;
          result.param_out   = {4'h5, sat15};
        end else begin
          result.param_out = 8'h00;
        end
      end
      EFF_EXT: begin
        result.command_out = CMD_EXT;
        result.param_out   = (p != 8'h00) ? 8'h01 : 8'h00;
      end
      EFF_JUMP: begin
        result.command_out = CMD_JUMP;
      end
      EFF_SPEED: begin
        result.command_out = CMD_TEMPO;
      end
      EFF_RELEASE: begin
        result.note_out       = '0;
        result.instrument_out = '0;
        result.key_off        = 1'b1;
        result.param_out      = 8'h00;
      end
      EFF_VOLUME: begin
        result.command_out = CMD_VOLSLIDE;
        if (p <= VOL_MAX) begin
          result.volume_set   = 1'b1;
          result.volume_value = p[6:0];
          result.command_out  = CMD_IDLE;
          result.param_out    = 8'h00;
        end else begin
          case (p[7:4]) inside
            4'h4:        result.param_out = {4'h0, lo};
            4'h5:        result.param_out = {lo, 4'h0};
            4'h6:        result.param_out = {4'hF, sat14};
            4'h7:        result.param_out = {sat14, 4'hF};
            [4'h8:4'hF]: begin
              result.command_out = CMD_IDLE;
              result.param_out   = 8'h00;
            end
            default: begin
              result.command_out = CMD_IDLE;
              result.param_out   = 8'h00;
            end
          endcase
        end
      end
      default: begin
        result.command_out = CMD_IDLE;
        result.param_out   = 8'h00;
      end
    endcase
  end

endmodule

>>> rtl/core/tracker_pattern_cell_translator_unit.sv
// ----------------------------------------------------------------------------
// Tracker pattern cell translator
// Turns raw four-byte pattern cells into normalized cells, one per clock while rsp_ready is high.
//
// Channels: a request (req_valid/req_ready, payload req) carries one raw
// cell; a response (rsp_valid/rsp_ready, payload rsp) carries the
// normalized cell. Every request yields exactly one response, in order.
// Path: an accepted request is registered in the input register, translated,
// then registered in the result register, which drives rsp.
// Throughput: one cell per cycle while rsp_ready is high; the input and the result
// register each hold one cell, with the translation logic between them.
// Stall: when rsp_ready is low the result register holds, the input
// register fills, and req_ready then drops until the response is taken.
// Reset: rst clears both valid flags; no cell is held afterwards.
// ----------------------------------------------------------------------------
module tracker_pattern_cell_translator_unit
  import tpct_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  tpct_cell_t   req,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output tpct_result_t rsp
);

  tpct_cell_t   held;
  logic         cell_valid;
  tpct_result_t xlated;
  logic         res_ready;

  assign res_ready = !rsp_valid || rsp_ready;
  assign req_ready = !cell_valid || res_ready;

  tpct_xlate u_xlate (
    .raw    (held),
    .result (xlated)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (req_ready) begin
      cell_valid <= req_valid;
    end
    if (req_valid && req_ready) begin
      held <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= cell_valid;
    end
    if (cell_valid && res_ready) begin
      rsp <= xlated;
    end
  end

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.key_off |->
      rsp.note_out == '0 && rsp.instrument_out == '0 && rsp.command_out == CMD_IDLE)
    else $error("key-off cell not cleared");

  a_volume_no_cmd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.volume_set |-> rsp.command_out == CMD_IDLE && rsp.param_out == 8'h00)
    else $error("set-volume cell carries a command");

  a_empty_note_no_ins: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.note_out == '0 |-> rsp.instrument_out == '0)
    else $error("instrument without note");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> cell_valid)
    else $error("accepted request lost");

  a_stall_keeps_cell: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !res_ready |=> cell_valid && $stable(held))
    else $error("input register changed during stall");

endmodule

>>> tb/sv/tpct_cell_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern cell translator checker
// Watches the request and response channels. It predicts the normalized cell
// for each accepted request, keeps the predictions in order, and compares
// every accepted response with the oldest one, field by field.
// ----------------------------------------------------------------------------
module tpct_cell_checker
  import tpct_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         req_ready,
  input  tpct_cell_t   req,
  input  logic         rsp_valid,
  input  logic         rsp_ready,
  input  tpct_result_t rsp,
  output int           mismatch_count,
  output int           outstanding
);

  tpct_result_t expected_cells[$];
  int           mismatches = 0;

  function automatic tpct_result_t translate_cell(input tpct_cell_t c);
    tpct_result_t r;
    logic [7:0]   p;
    logic [7:0]   p_sat15;
    logic [3:0]   nib_sat14;
    r         = '0;
    p         = c.effect_param;
    p_sat15   = (p > 8'h0F) ? 8'h0F : p;
    nib_sat14 = (p[3:0] > 4'hE) ? 4'hE : p[3:0];
    r.param_out = p;
    if (c.note_code >= 8'd1 && c.note_code <= NOTE_LIMIT) begin
      r.note_out       = c.note_code[6:0] + NOTE_OFFSET;
      r.instrument_out = c.instrument_code + 8'd1;
    end
    case (c.effect_code)
      EFF_PORTA_DOWN: begin
        r.command_out = CMD_PORTA_DOWN;
        r.param_out   = {4'h0, p[3:0]};
      end
      EFF_PORTA_UP: begin
        r.command_out = CMD_PORTA_UP;
        r.param_out   = {4'h0, p[3:0]};
      end
      EFF_ARP: begin
        if (p != 8'd0) r.command_out = CMD_ARP;
        else r.param_out = '0;
      end
      EFF_SLIDE_DN, EFF_SLIDE_UP: begin
        if (p != 8'd0) begin
          r.command_out = (c.effect_code == EFF_SLIDE_DN) ? CMD_SLIDE_DOWN : CMD_SLIDE_UP;
          r.param_out   = 8'h10 | p_sat15;
        end else begin
          r.param_out = '0;
        end
      end
      EFF_FSLIDE_DN, EFF_FSLIDE_UP: begin
        if (p != 8'd0) begin
          r.command_out = (c.effect_code == EFF_FSLIDE_DN) ? CMD_SLIDE_DOWN : CMD_SLIDE_UP;
          r.param_out   = 8'h50 | p_sat15;
        end else begin
          r.param_out = '0;
        end
      end
      EFF_EXT: begin
        r.command_out = CMD_EXT;
        r.param_out   = (p != 8'd0) ? 8'd1 : 8'd0;
      end
      EFF_JUMP:  r.command_out = CMD_JUMP;
      EFF_SPEED: r.command_out = CMD_TEMPO;
      EFF_RELEASE: begin
        r         = '0;
        r.key_off = 1'b1;
      end
      EFF_VOLUME: begin
        r.command_out = CMD_VOLSLIDE;
        case (p[7:4])
          4'd0, 4'd1, 4'd2, 4'd3: begin
            r.volume_set   = 1'b1;
            r.volume_value = p[6:0];
            r.command_out  = CMD_IDLE;
            r.param_out    = '0;
          end
          4'd4: begin
            if (p == VOL_MAX) begin
              r.volume_set   = 1'b1;
              r.volume_value = p[6:0];
              r.command_out  = CMD_IDLE;
              r.param_out    = '0;
            end else begin
              r.param_out = {4'h0, p[3:0]};
            end
          end
          4'd5: r.param_out = {p[3:0], 4'h0};
          4'd6: r.param_out = {4'hF, nib_sat14};
          4'd7: r.param_out = {nib_sat14, 4'hF};
          default: begin
            r.command_out = CMD_IDLE;
            r.param_out   = '0;
          end
        endcase
      end
      default: begin
        r.command_out = CMD_IDLE;
        r.param_out   = '0;
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    tpct_result_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_cells = {expected_cells, translate_cell(req)};
      if (rsp_valid && rsp_ready) begin
        if (expected_cells.size() == 0) begin
          $error("response with no request outstanding");
          mismatches++;
        end else begin
          want = expected_cells.pop_front();
          compare_field("note_out", want.note_out, rsp.note_out);
          compare_field("key_off", want.key_off, rsp.key_off);
          compare_field("instrument_out", want.instrument_out, rsp.instrument_out);
          compare_field("volume_set", want.volume_set, rsp.volume_set);
          compare_field("volume_value", want.volume_value, rsp.volume_value);
          compare_field("command_out", want.command_out, rsp.command_out);
          compare_field("param_out", want.param_out, rsp.param_out);
        end
      end
    end
    mismatch_count <= mismatches;
    outstanding    <= expected_cells.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern cell translator testbench
// Sends a directed set of cells covering note limits, every effect and the
// volume forms, then random cells weighted toward known effects, with bursty
// requests and a stalling receiver. A checker beside the block predicts and
// compares; the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tpct_pkg::*;

  localparam logic [7:0] EFF_NONE     = 8'd0;
  localparam int         RANDOM_CELLS = 1525;

  logic         clk = 1'b0;
  logic         rst;
  logic         req_valid;
  logic         req_ready;
  tpct_cell_t   req;
  logic         rsp_valid;
  logic         rsp_ready;
  tpct_result_t rsp;
  int           mismatch_count;
  int           outstanding;
  int           burst_left = 0;

  always #2 clk = ~clk;

  tracker_pattern_cell_translator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  tpct_cell_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  task automatic issue_cell(input logic [7:0] note, input logic [7:0] ins,
                            input logic [7:0] eff, input logic [7:0] param);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= '{note, ins, eff, param};
    do @(posedge clk); while (!req_ready);
    burst_left--;
  endtask

  function automatic logic [7:0] pick_effect();
    case ($urandom_range(0, 12))
      0:  return EFF_NONE;
      1:  return EFF_PORTA_DOWN;
      2:  return EFF_PORTA_UP;
      3:  return EFF_ARP;
      4:  return EFF_SLIDE_DN;
      5:  return EFF_EXT;
      6:  return EFF_FSLIDE_UP;
      7:  return EFF_FSLIDE_DN;
      8:  return EFF_JUMP;
      9:  return EFF_RELEASE;
      10: return EFF_SPEED;
      11: return EFF_SLIDE_UP;
      default: return EFF_VOLUME;
    endcase
  endfunction

  function automatic logic [7:0] pick_param();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'($urandom_range(0, 15));
      4:       return VOL_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_note();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1, 2:    return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 36));
    endcase
  endfunction

  initial begin
    int hi;
    int lo;
    int round;
    rsp_ready <= 1'b0;
    round = 0;
    do @(posedge clk); while (rst);
    forever begin
      hi = (round % 8 == 7) ? 40 : $urandom_range(1, 10);
      lo = $urandom_range(0, 4);
      rsp_ready <= 1'b1;
      repeat (hi) @(posedge clk);
      if (lo != 0) begin
        rsp_ready <= 1'b0;
        repeat (lo) @(posedge clk);
      end
      round++;
    end
  end

  initial begin
    int waited;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    issue_cell(8'd1,   8'd0,   EFF_NONE,       8'h00);
    issue_cell(8'd36,  8'd255, EFF_PORTA_DOWN, 8'hFF);
    issue_cell(8'd37,  8'd5,   EFF_PORTA_UP,   8'hFF);
    issue_cell(8'd0,   8'd255, EFF_ARP,        8'h00);
    issue_cell(8'd255, 8'd7,   EFF_ARP,        8'hA5);
    issue_cell(8'd12,  8'd1,   EFF_SLIDE_DN,   8'h03);
    issue_cell(8'd20,  8'd2,   EFF_SLIDE_DN,   8'hFF);
    issue_cell(8'd3,   8'd3,   EFF_SLIDE_UP,   8'h00);
    issue_cell(8'd4,   8'd4,   EFF_SLIDE_UP,   8'h20);
    issue_cell(8'd5,   8'd5,   EFF_FSLIDE_DN,  8'h0F);
    issue_cell(8'd6,   8'd6,   EFF_FSLIDE_DN,  8'h00);
    issue_cell(8'd7,   8'd7,   EFF_FSLIDE_UP,  8'h80);
    issue_cell(8'd8,   8'd8,   EFF_EXT,        8'h00);
    issue_cell(8'd9,   8'd9,   EFF_EXT,        8'h7F);
    issue_cell(8'd10,  8'd10,  EFF_JUMP,       8'hFF);
    issue_cell(8'd10,  8'd3,   EFF_RELEASE,    8'h55);
    issue_cell(8'd11,  8'd11,  EFF_SPEED,      8'h06);
    issue_cell(8'd13,  8'd12,  EFF_VOLUME,     8'h00);
    issue_cell(8'd14,  8'd13,  EFF_VOLUME,     8'h3F);
    issue_cell(8'd15,  8'd14,  EFF_VOLUME,     VOL_MAX);
    issue_cell(8'd16,  8'd15,  EFF_VOLUME,     8'h4F);
    issue_cell(8'd17,  8'd16,  EFF_VOLUME,     8'h5A);
    issue_cell(8'd18,  8'd17,  EFF_VOLUME,     8'h6F);
    issue_cell(8'd19,  8'd18,  EFF_VOLUME,     8'h7E);
    issue_cell(8'd21,  8'd19,  EFF_VOLUME,     8'h8C);
    issue_cell(8'd22,  8'd128, EFF_VOLUME,     8'hFF);
    issue_cell(8'd23,  8'd64,  8'd3,           8'h44);
    issue_cell(8'd128, 8'd32,  8'd255,         8'h99);

    repeat (RANDOM_CELLS) begin
      issue_cell(pick_note(), 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 9) < 7) ? pick_effect() : 8'($urandom_range(0, 255)),
                 pick_param());
    end

    req_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
